// File: rtl/tkwm_pkg.sv
// ----------------------------------------------------------------------------
// tkwm_pkg
// Shared widths, defaults and the scan token flag type of the k-way merge.
// ----------------------------------------------------------------------------
package tkwm_pkg;

  // Fixed field widths
  localparam int STAMP_W  = 64;
  localparam int STREAM_W = 3;
  localparam int SIU_W    = 4;

  // Parameter defaults
  localparam int NUM_STREAMS_DEF  = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Stream count after reset
  localparam logic [SIU_W-1:0] SIU_RESET = 4'd8;

  // Control flags that travel with the scan token
  typedef struct packed {
    logic vld;      // token present in this stage
    logic any;      // a candidate head has been picked
    logic blocked;  // a live stream that has not ended has an empty head
  } tkwm_flags_t;

endpackage

// File: rtl/tkwm_if.sv
// ----------------------------------------------------------------------------
// tkwm_if
// Valid/ready channels of the k-way merge: input, result and config write.
// ----------------------------------------------------------------------------
interface tkwm_in_if import tkwm_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [STREAM_W-1:0]     stream;
  logic [STAMP_W-1:0]      stamp;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, mode, stream, stamp, payload, input ready);
  modport sink   (input valid, mode, stream, stamp, payload, output ready);
endinterface

interface tkwm_out_if import tkwm_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [STREAM_W-1:0]     from_stream;
  logic [STAMP_W-1:0]      out_stamp;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    back_in_time;

  modport source (output valid, from_stream, out_stamp, out_payload, back_in_time,
                  input ready);
  modport sink   (input valid, from_stream, out_stamp, out_payload, back_in_time,
                  output ready);
endinterface

interface tkwm_cfg_if import tkwm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SIU_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/tkwm_cell.sv
// ----------------------------------------------------------------------------
// tkwm_cell
// One stream head slot plus one stage of the minimum scan chain.
// ----------------------------------------------------------------------------
module tkwm_cell import tkwm_pkg::*; #(
  parameter int CELL_IDX     = 0,
  parameter int IW           = 3,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SIU_W-1:0]        siu,
  input  logic                    served_vld,
  input  logic [IW-1:0]           served_idx,
  // write side
  input  logic                    wr_acc,
  input  logic                    wr_mode,
  input  logic [STREAM_W-1:0]     wr_stream,
  input  logic [STAMP_W-1:0]      wr_stamp,
  input  logic [PAYLOAD_BITS-1:0] wr_data,
  // release of the emitted head
  input  logic                    clr_en,
  input  logic [IW-1:0]           clr_idx,
  // token from the previous cell
  input  tkwm_flags_t             tin_flags,
  input  logic [STAMP_W-1:0]      tin_stamp,
  input  logic [IW-1:0]           tin_idx,
  input  logic [PAYLOAD_BITS-1:0] tin_data,
  // token to the next cell
  output tkwm_flags_t             tout_flags,
  output logic [STAMP_W-1:0]      tout_stamp,
  output logic [IW-1:0]           tout_idx,
  output logic [PAYLOAD_BITS-1:0] tout_data
);

  logic                    full_r, full_nxt;
  logic                    ended_r, ended_nxt;
  logic [STAMP_W-1:0]      stamp_r;
  logic [PAYLOAD_BITS-1:0] data_r;
  logic                    live;
  logic                    wr_hit;
  logic                    take;
  tkwm_flags_t             flags_r, flags_nxt;
  logic [STAMP_W-1:0]      tstamp_r, tstamp_nxt;
  logic [IW-1:0]           tidx_r, tidx_nxt;
  logic [PAYLOAD_BITS-1:0] tdata_r, tdata_nxt;

  // Stream takes part while its index is below the configured count
  assign live   = CELL_IDX < int'(siu);
  assign wr_hit = wr_acc && (int'(wr_stream) == CELL_IDX) && live && !ended_r && !full_r;

  // Slot flags: fill or end on a write, drop the head when emitted
  always_comb begin
    full_nxt  = full_r;
    ended_nxt = ended_r;
    if (wr_hit && wr_mode) begin
      ended_nxt = 1'b1;
    end else if (wr_hit) begin
      full_nxt = 1'b1;
    end else if (clr_en && clr_idx == IW'(CELL_IDX)) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= 1'b0;
      ended_r <= 1'b0;
    end else begin
      full_r  <= full_nxt;
      ended_r <= ended_nxt;
    end
  end

  // Head contents
  always_ff @(posedge clk) begin
    if (wr_hit && !wr_mode) begin
      stamp_r <= wr_stamp;
      data_r  <= wr_data;
    end
  end

  // Compare own head with the running candidate; ties go to the last served, else lower index
  assign take = live && !ended_r && full_r &&
                (!tin_flags.any || (stamp_r < tin_stamp) ||
                 ((stamp_r == tin_stamp) && served_vld && (served_idx == IW'(CELL_IDX))));

  always_comb begin
    flags_nxt         = tin_flags;
    tstamp_nxt        = tin_stamp;
    tidx_nxt          = tin_idx;
    tdata_nxt         = tin_data;
    flags_nxt.blocked = tin_flags.blocked || (live && !ended_r && !full_r);
    if (take) begin
      flags_nxt.any = 1'b1;
      tstamp_nxt    = stamp_r;
      tidx_nxt      = IW'(CELL_IDX);
      tdata_nxt     = data_r;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tstamp_r <= tstamp_nxt;
    tidx_r   <= tidx_nxt;
    tdata_r  <= tdata_nxt;
  end

  assign tout_flags = flags_r;
  assign tout_stamp = tstamp_r;
  assign tout_idx   = tidx_r;
  assign tout_data  = tdata_r;

endmodule

// File: rtl/timestamp_k_way_merge_core.sv
// ----------------------------------------------------------------------------
// timestamp_k_way_merge_core
// Merges time-ordered record streams into one stream, smallest stamp first.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction either fills the head slot of a stream (mode 0)
//            or marks that stream as ended (mode 1). Transactions for a full
//            slot, an ended stream or a stream out of use are dropped.
//   out_ch : zero or one result per input transaction. A result is produced
//            once each live, unended stream has a head; it carries the stream
//            to refill next and flags a stamp below the previous one.
//   cfg_ch : writes streams_in_use; write it only while the block is idle.
// Timing:
//   The scan token walks the row one cell per cycle; then the winner is
//   captured and moved into the output register. in_ch is ready only while
//   idle, so the next transaction is taken once the result is committed, or
//   once the scan ends when the transaction yields no result.
// Reset: all head slots empty, no stream ended, streams_in_use = 8, no stream
//   served yet, previous stamp zero.
// Stall: a result waits in the output register while out_ch.ready is low;
//   the next input transaction is still taken, but its own result waits
//   until the output register is free.
// ----------------------------------------------------------------------------
module timestamp_k_way_merge_core import tkwm_pkg::*; #(
  parameter int NUM_STREAMS  = NUM_STREAMS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tkwm_in_if.sink   in_ch,
  tkwm_out_if.source out_ch,
  tkwm_cfg_if.sink  cfg_ch
);

  localparam int IW = $clog2(NUM_STREAMS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic                    start_r;
  logic [SIU_W-1:0]        siu_r;
  logic                    served_vld_r;
  logic [IW-1:0]           served_idx_r;
  logic [STAMP_W-1:0]      prev_r;
  logic [STAMP_W-1:0]      res_stamp_r;
  logic [IW-1:0]           res_idx_r;
  logic [PAYLOAD_BITS-1:0] res_data_r;
  logic                    out_valid_r;
  logic [STREAM_W-1:0]     out_from_r;
  logic [STAMP_W-1:0]      out_stamp_r;
  logic [PAYLOAD_BITS-1:0] out_data_r;
  logic                    out_back_r;
  logic                    in_acc;
  logic                    commit;
  logic                    capture;

  tkwm_flags_t             tok_flags [NUM_STREAMS+1];
  logic [STAMP_W-1:0]      tok_stamp [NUM_STREAMS+1];
  logic [IW-1:0]           tok_idx   [NUM_STREAMS+1];
  logic [PAYLOAD_BITS-1:0] tok_data  [NUM_STREAMS+1];

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign capture = (state_r == ST_SCAN) && tok_flags[NUM_STREAMS].vld;
  assign commit  = (state_r == ST_COMMIT) && (!out_valid_r || out_ch.ready);

  // Sequence one transaction: scan, capture winner, commit to output if the scan yields a result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (capture) begin
          if (tok_flags[NUM_STREAMS].any && !tok_flags[NUM_STREAMS].blocked) begin
            state_nxt = ST_COMMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COMMIT: begin
        if (commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      siu_r <= SIU_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      siu_r <= cfg_ch.data;
    end
  end

  // Inject a fresh token in the cycle after the slot update
  always_comb begin
    tok_flags[0]         = '0;
    tok_flags[0].vld     = start_r;
    tok_stamp[0]         = '0;
    tok_idx[0]           = '0;
    tok_data[0]          = '0;
  end

  // Row of head cells
  for (genvar g = 0; g < NUM_STREAMS; g++) begin : g_cell
    tkwm_cell #(
      .CELL_IDX    (g),
      .IW          (IW),
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .siu       (siu_r),
      .served_vld(served_vld_r),
      .served_idx(served_idx_r),
      .wr_acc    (in_acc),
      .wr_mode   (in_ch.mode),
      .wr_stream (in_ch.stream),
      .wr_stamp  (in_ch.stamp),
      .wr_data   (in_ch.payload),
      .clr_en    (commit),
      .clr_idx   (res_idx_r),
      .tin_flags (tok_flags[g]),
      .tin_stamp (tok_stamp[g]),
      .tin_idx   (tok_idx[g]),
      .tin_data  (tok_data[g]),
      .tout_flags(tok_flags[g+1]),
      .tout_stamp(tok_stamp[g+1]),
      .tout_idx  (tok_idx[g+1]),
      .tout_data (tok_data[g+1])
    );
  end

  // Hold the winning head until the output register is free
  always_ff @(posedge clk) begin
    if (capture) begin
      res_stamp_r <= tok_stamp[NUM_STREAMS];
      res_idx_r   <= tok_idx[NUM_STREAMS];
      res_data_r  <= tok_data[NUM_STREAMS];
    end
  end

  // Merge history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      served_vld_r <= 1'b0;
      served_idx_r <= '0;
      prev_r       <= '0;
    end else if (commit) begin
      served_vld_r <= 1'b1;
      served_idx_r <= res_idx_r;
      prev_r       <= res_stamp_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_from_r  <= STREAM_W'(res_idx_r);
      out_stamp_r <= res_stamp_r;
      out_data_r  <= res_data_r;
      out_back_r  <= (res_stamp_r < prev_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.from_stream  = out_from_r;
  assign out_ch.out_stamp    = out_stamp_r;
  assign out_ch.out_payload  = out_data_r;
  assign out_ch.back_in_time = out_back_r;

endmodule

// File: rtl/tkwm_checker.sv
// ----------------------------------------------------------------------------
// tkwm_checker
// Port-level checks on the k-way merge, attached to the merge core by bind.
// ----------------------------------------------------------------------------
module tkwm_checker import tkwm_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STREAM_W-1:0]     out_from,
  input logic [STAMP_W-1:0]      out_stamp,
  input logic [PAYLOAD_BITS-1:0] out_payload
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_from) && $stable(out_stamp) && $stable(out_payload))
    else $error("result changed while stalled");

  // An accepted transaction starts a scan, so input closes next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during a scan");

  // A new result only comes out of a finished scan
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(!in_ready))
    else $error("result appeared without a scan");

endmodule

bind timestamp_k_way_merge_core tkwm_checker #(
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_tkwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_from   (out_ch.from_stream),
  .out_stamp  (out_ch.out_stamp),
  .out_payload(out_ch.out_payload)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for timestamp_k_way_merge_core. A short table of
// directed transactions covers the extremes, the tie rules and the dropped
// cases. Random phases under several stream counts follow. Results are
// checked against the table's records where given, else against an in-bench
// merge predictor, with random sender bursts and random receiver stalls.
// ----------------------------------------------------------------------------
module tb_top import tkwm_pkg::*;;

  localparam int NUM       = NUM_STREAMS_DEF;
  localparam int PAYLOAD_W = PAYLOAD_BITS_DEF;
  localparam int LATENCY   = NUM + 3;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_END    = 1'b1;
  localparam logic [3:0] SERVED_NONE = 4'd15;

  typedef struct packed {
    logic                 mode;
    logic [STREAM_W-1:0]  stream;
    logic [STAMP_W-1:0]   stamp;
    logic [PAYLOAD_W-1:0] payload;
  } merge_item_t;

  typedef struct packed {
    logic [STREAM_W-1:0]  from_stream;
    logic [STAMP_W-1:0]   stamp;
    logic [PAYLOAD_W-1:0] payload;
    logic                 back_in_time;
  } merge_rec_t;

  typedef struct packed {
    merge_item_t item;
    logic        typed;
    merge_rec_t  rec;
  } directed_row_t;

  typedef struct packed {
    logic [SIU_W-1:0] streams;
    logic [15:0]      goal;
    logic             allow_end;
  } phase_t;

  localparam merge_rec_t NO_REC = '0;

  logic clk;
  logic rst_n;

  tkwm_in_if  #(.PAYLOAD_BITS(PAYLOAD_W)) in_ch ();
  tkwm_out_if #(.PAYLOAD_BITS(PAYLOAD_W)) out_ch ();
  tkwm_cfg_if                             cfg_ch ();

  timestamp_k_way_merge_core #(
    .NUM_STREAMS (NUM),
    .PAYLOAD_BITS(PAYLOAD_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor state: head slots, tie memory and the stream count
  logic [STAMP_W-1:0]   slot_stamp   [NUM];
  logic [PAYLOAD_W-1:0] slot_payload [NUM];
  bit                   slot_full    [NUM];
  bit                   slot_ended   [NUM];
  logic [3:0]           last_served;
  bit                   last_served_vld;
  logic [STAMP_W-1:0]   last_stamp;
  logic [SIU_W-1:0]     live_streams;

  merge_rec_t  pending_records[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  logic [STAMP_W-1:0] stamp_now;

  // Directed table: stamps picked so that ties, drops and a step back in
  // time happen at known rows
  directed_row_t directed_rows [17] = '{
    '{'{MODE_RECORD, 3'd0, 64'd100, 32'hFFFF_FFFF}, 1'b0, NO_REC},
    '{'{MODE_RECORD, 3'd1, 64'd100, 32'h0000_0000}, 1'b0, NO_REC},
    '{'{MODE_RECORD, 3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0001}, 1'b0, NO_REC},
    '{'{MODE_RECORD, 3'd3, 64'd200, 32'h1234_5678}, 1'b0, NO_REC},
    '{'{MODE_RECORD, 3'd4, 64'd300, 32'h8765_4321}, 1'b0, NO_REC},
    '{'{MODE_RECORD, 3'd5, 64'd400, 32'h5555_5555}, 1'b0, NO_REC},
    '{'{MODE_RECORD, 3'd6, 64'd500, 32'hAAAA_AAAA}, 1'b0, NO_REC},
    // last head arrives: smallest stamp goes out first
    '{'{MODE_RECORD, 3'd7, 64'd0, 32'hA5A5_A5A5}, 1'b1,
      '{3'd7, 64'd0, 32'hA5A5_A5A5, 1'b0}},
    // record and end mark for a full slot are dropped
    '{'{MODE_RECORD, 3'd0, 64'd5, 32'hDEAD_BEEF}, 1'b0, NO_REC},
    '{'{MODE_END, 3'd0, 64'd0, 32'h0000_0000}, 1'b0, NO_REC},
    // three-way tie: the stream served last wins
    '{'{MODE_RECORD, 3'd7, 64'd100, 32'h1111_1111}, 1'b1,
      '{3'd7, 64'd100, 32'h1111_1111, 1'b0}},
    '{'{MODE_RECORD, 3'd7, 64'd100, 32'h2222_2222}, 1'b1,
      '{3'd7, 64'd100, 32'h2222_2222, 1'b0}},
    // end stream 7: tie falls to the lowest index
    '{'{MODE_END, 3'd7, 64'd0, 32'h0000_0000}, 1'b1,
      '{3'd0, 64'd100, 32'hFFFF_FFFF, 1'b0}},
    '{'{MODE_RECORD, 3'd0, 64'd50, 32'h3333_3333}, 1'b1,
      '{3'd0, 64'd50, 32'h3333_3333, 1'b1}},
    // record for an ended stream is dropped
    '{'{MODE_RECORD, 3'd7, 64'd1, 32'h4444_4444}, 1'b0, NO_REC},
    '{'{MODE_RECORD, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000}, 1'b1,
      '{3'd1, 64'd100, 32'h0000_0000, 1'b0}},
    '{'{MODE_RECORD, 3'd1, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF}, 1'b0, NO_REC}
  };

  // Random phases: stream count, transactions that change state, end marks
  phase_t phase_plan [8] = '{
    '{4'd1,  16'd100, 1'b0},
    '{4'd15, 16'd150, 1'b0},
    '{4'd0,  16'd10,  1'b0},
    '{4'd3,  16'd150, 1'b0},
    '{4'd5,  16'd150, 1'b0},
    '{4'd2,  16'd100, 1'b0},
    '{4'd9,  16'd100, 1'b0},
    '{4'd8,  16'd150, 1'b1}
  };

  // Apply one transaction to the predictor; report whether it changed state
  // and whether it releases a record
  function automatic void merge_predict(input merge_item_t it, output bit took,
                                        output bit emits, output merge_rec_t rec);
    int lim;
    int best;
    bit any;
    lim   = (live_streams > NUM) ? NUM : int'(live_streams);
    took  = 1'b0;
    emits = 1'b0;
    rec   = '0;
    any   = 1'b0;
    best  = 0;
    if (int'(it.stream) < lim && !slot_ended[it.stream] && !slot_full[it.stream]) begin
      took = 1'b1;
      if (it.mode == MODE_END) begin
        slot_ended[it.stream] = 1'b1;
      end else begin
        slot_stamp[it.stream]   = it.stamp;
        slot_payload[it.stream] = it.payload;
        slot_full[it.stream]    = 1'b1;
      end
    end
    // Scan live slots; any empty live slot that has not ended holds the merge
    for (int s = 0; s < lim; s++) begin
      if (slot_ended[s]) continue;
      if (!slot_full[s]) return;
      if (!any) begin
        best = s;
        any  = 1'b1;
      end else if (slot_stamp[s] < slot_stamp[best]) begin
        best = s;
      end else if (slot_stamp[s] == slot_stamp[best] && last_served_vld &&
                   last_served == s) begin
        best = s;
      end
    end
    if (!any) return;
    emits            = 1'b1;
    rec.from_stream  = best[STREAM_W-1:0];
    rec.stamp        = slot_stamp[best];
    rec.payload      = slot_payload[best];
    rec.back_in_time = slot_stamp[best] < last_stamp;
    last_stamp       = slot_stamp[best];
    slot_full[best]  = 1'b0;
    last_served      = best[3:0];
    last_served_vld  = 1'b1;
  endfunction

  // Drive one transaction in bursts with random gaps; return at acceptance
  task automatic send_item(input merge_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= it.mode;
    in_ch.stream  <= it.stream;
    in_ch.stamp   <= it.stamp;
    in_ch.payload <= it.payload;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus: reset, directed table, then random phases
  initial begin
    merge_item_t item;
    merge_rec_t  rec;
    bit          took;
    bit          emits;
    int unsigned taken;
    int unsigned tries;
    int unsigned pick;
    int          lim;
    int          empties[$];

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_RECORD;
    in_ch.stream   <= '0;
    in_ch.stamp    <= '0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= SIU_RESET;

    foreach (slot_full[s]) begin
      slot_full[s]  = 1'b0;
      slot_ended[s] = 1'b0;
    end
    last_served     = SERVED_NONE;
    last_served_vld = 1'b0;
    last_stamp      = '0;
    live_streams    = SIU_RESET;
    stamp_now       = 64'd1000;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      merge_predict(directed_rows[r].item, took, emits, rec);
      send_item(directed_rows[r].item);
      if (directed_rows[r].typed) begin
        pending_records.insert(pending_records.size(), directed_rows[r].rec);
      end else if (emits) begin
        pending_records.insert(pending_records.size(), rec);
      end
    end

    foreach (phase_plan[p]) begin
      // Drain and let dropped transactions finish before the register write
      in_ch.valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clk);
      repeat (LATENCY + 5) @(posedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= phase_plan[p].streams;
      do @(posedge clk); while (!cfg_ch.ready);
      cfg_ch.valid <= 1'b0;
      live_streams = phase_plan[p].streams;

      taken = 0;
      for (tries = 0; tries < 4 * phase_plan[p].goal && taken < phase_plan[p].goal;
           tries++) begin
        lim          = (live_streams > NUM) ? NUM : int'(live_streams);
        pick         = $urandom_range(0, 99);
        item.mode    = MODE_RECORD;
        item.payload = $urandom;
        if (pick == 0) stamp_now = {$urandom, $urandom};
        if (pick < 72) begin
          // Well formed: refill an empty live slot with a non-decreasing stamp
          empties.delete();
          for (int s = 0; s < lim; s++) begin
            if (!slot_ended[s] && !slot_full[s]) empties.insert(empties.size(), s);
          end
          if (empties.size() != 0) begin
            item.stream = STREAM_W'(empties[$urandom_range(0, empties.size() - 1)]);
          end else begin
            item.stream = STREAM_W'($urandom_range(0, NUM - 1));
          end
          stamp_now  = stamp_now + STAMP_W'($urandom_range(0, 3));
          item.stamp = stamp_now;
        end else if (pick < 87) begin
          // Noise: any stream, any stamp, either mode
          item.stream = STREAM_W'($urandom_range(0, NUM - 1));
          item.stamp  = {$urandom, $urandom};
          item.mode   = 1'($urandom_range(0, 1));
        end else begin
          // Broken order: extremes or a stamp at or behind the current time
          item.stream = STREAM_W'($urandom_range(0, NUM - 1));
          case ($urandom_range(0, 2))
            0:       item.stamp = '0;
            1:       item.stamp = '1;
            default: item.stamp = stamp_now - STAMP_W'($urandom_range(0, 40));
          endcase
        end
        // Keep streams alive until the closing phase
        if (item.mode == MODE_END && !phase_plan[p].allow_end &&
            int'(item.stream) < lim && !slot_ended[item.stream] &&
            !slot_full[item.stream]) begin
          item.mode = MODE_RECORD;
        end
        merge_predict(item, took, emits, rec);
        send_item(item);
        if (emits) pending_records.insert(pending_records.size(), rec);
        if (took) taken++;
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: drives out_ch.ready in one of four random stall styles
  initial begin
    int unsigned style;
    int unsigned left;
    logic [7:0]  mask;
    left = 0;
    style = 0;
    mask = '1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        mask  = 8'($urandom);
        left  = $urandom_range(20, 200);
      end
      left--;
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: begin
          mask = {mask[6:0], mask[7]};
          out_ch.ready <= mask[0];
        end
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Check each result transaction against the oldest expected record
  always @(posedge clk) begin
    merge_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result at %0t: stream %0d stamp %h payload %h",
                   $time, out_ch.from_stream, out_ch.out_stamp, out_ch.out_payload);
        end
      end else begin
        want = pending_records.pop_front();
        if (out_ch.from_stream !== want.from_stream || out_ch.out_stamp !== want.stamp ||
            out_ch.out_payload !== want.payload ||
            out_ch.back_in_time !== want.back_in_time) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("wrong result at %0t (expected / actual):", $time);
            $display("  stream %0d / %0d  stamp %h / %h", want.from_stream,
                     out_ch.from_stream, want.stamp, out_ch.out_stamp);
            $display("  payload %h / %h  back_in_time %0b / %0b", want.payload,
                     out_ch.out_payload, want.back_in_time, out_ch.back_in_time);
          end
        end
      end
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
